// ----- rtl/scap_pkg.sv -----
// Shared types, constants and decode tables for the ATR parser.
`default_nettype none
package scap_pkg;
  localparam int MaxAtrBytesDefault = 64;
  localparam logic [7:0] TsDirect = 8'h3B;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadTs = 3'd1;
  localparam logic [2:0] StNoIface = 3'd2;
  localparam logic [2:0] StBadF = 3'd3;
  localparam logic [2:0] StBadD = 3'd4;
  localparam logic [2:0] StBadTa2 = 3'd5;
  localparam logic [2:0] StLength = 3'd6;
  localparam logic [2:0] StTck = 3'd7;

  // controller to datapath commands
  typedef struct packed {
    logic clear;       // back to reset values
    logic div_start;   // load divider
    logic div_step;    // one quotient bit
    logic div_sel_bwt; // 0: etu division, 1: bwt division
    logic fin_etu;     // latch etu from quotient
    logic fin_bwt;     // latch bwt from quotient
  } scap_cmd_t;

  typedef struct packed {
    logic [2:0] status;
  } scap_sts_t;

  function automatic logic [11:0] fi_lookup(input logic [3:0] c);
    logic [11:0] r;
    case (c)
      4'd0, 4'd1: r = 12'd372;
      4'd2: r = 12'd558;
      4'd3: r = 12'd744;
      4'd4: r = 12'd1116;
      4'd5: r = 12'd1488;
      4'd6: r = 12'd1860;
      4'd9: r = 12'd512;
      4'd10: r = 12'd768;
      4'd11: r = 12'd1024;
      4'd12: r = 12'd1536;
      4'd13: r = 12'd2048;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] f_lookup(input logic [3:0] c);
    logic [4:0] r;
    case (c)
      4'd0: r = 5'd4;
      4'd1, 4'd9: r = 5'd5;
      4'd2: r = 5'd6;
      4'd3: r = 5'd8;
      4'd4: r = 5'd12;
      4'd5: r = 5'd16;
      4'd6, 4'd13: r = 5'd20;
      4'd10: r = 5'd7;
      4'd11: r = 5'd10;
      4'd12: r = 5'd15;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] d_lookup(input logic [3:0] c);
    logic [6:0] r;
    case (c)
      4'd1: r = 7'd1;
      4'd2: r = 7'd2;
      4'd3: r = 7'd4;
      4'd4: r = 7'd8;
      4'd5: r = 7'd16;
      4'd6: r = 7'd32;
      4'd7: r = 7'd64;
      4'd8: r = 7'd12;
      4'd9: r = 7'd20;
      default: r = 7'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/scap_datapath.sv -----
// Datapath: ATR byte parsing registers, restoring divider and timing products.
`default_nettype none
module scap_datapath #(
  parameter int MAX_ATR_BYTES = scap_pkg::MaxAtrBytesDefault
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire logic [7:0]        atr_byte,
  input  wire scap_pkg::scap_cmd_t cmd,
  output scap_pkg::scap_sts_t    sts,
  output logic [6:0]             etu,
  output logic [11:0]            fi,
  output logic [6:0]             di,
  output logic                   t1_en,
  output logic [7:0]             ifsc,
  output logic [7:0]             edc,
  output logic [7:0]             n_guard,
  output logic [7:0]             wi,
  output logic [21:0]            bwt,
  output logic [12:0]            cwt,
  output logic [11:0]            bgt
);
  localparam int PosW = $clog2(MAX_ATR_BYTES + 1);
  localparam logic [2:0] PhTs = 3'd0, PhT0 = 3'd1, PhIface = 3'd2, PhHist = 3'd3,
                         PhTck = 3'd4, PhAfter = 3'd5, PhDrain = 3'd6;

  logic [PosW-1:0] pos_r;
  logic [2:0] ph_r, ph_nxt;
  logic [3:0] pend_r, pend_nxt, hist_r, hist_nxt;
  logic [4:0] grp_r, grp_nxt, proto_r, proto_nxt;
  logic [7:0] xor_r;
  logic [2:0] err_r, err_nxt;
  logic [11:0] fi_r, fi_nxt;
  logic [4:0] f_r, f_nxt;
  logic [6:0] d_r, d_nxt;
  logic [7:0] ifsc_r, ifsc_nxt, edc_r, edc_nxt, n_r, n_nxt, wi_r, wi_nxt;
  logic [3:0] bwi_r, bwi_nxt, cwi_r, cwi_nxt;
  logic t1_r, t1_nxt;

  logic [23:0] dend_r;  // shifting dividend
  logic [11:0] rem_r;
  logic [11:0] dvs_r;
  logic [6:0] etu_r;
  logic [21:0] bwt_r;
  logic [12:0] rem_try;

  always_comb begin
    logic fl;
    logic [2:0] fc;
    ph_nxt = ph_r; pend_nxt = pend_r; hist_nxt = hist_r; grp_nxt = grp_r;
    proto_nxt = proto_r; err_nxt = err_r; fi_nxt = fi_r; f_nxt = f_r; d_nxt = d_r;
    ifsc_nxt = ifsc_r; edc_nxt = edc_r; n_nxt = n_r; wi_nxt = wi_r;
    bwi_nxt = bwi_r; cwi_nxt = cwi_r; t1_nxt = t1_r;
    fl = 1'b0; fc = scap_pkg::StOk;
    if (pos_r >= PosW'(MAX_ATR_BYTES)) begin
      fl = 1'b1; fc = scap_pkg::StLength;
    end else begin
      case (ph_r)
        PhTs: if (atr_byte != scap_pkg::TsDirect) begin
          fl = 1'b1; fc = scap_pkg::StBadTs;
        end else ph_nxt = PhT0;
        PhT0: begin
          hist_nxt = atr_byte[3:0];
          pend_nxt = atr_byte[7:4];
          if (atr_byte[7:4] == 4'd0) begin
            fl = 1'b1; fc = scap_pkg::StNoIface;
          end else ph_nxt = PhIface;
        end
        PhIface: begin
          if (pend_r[0]) begin
            pend_nxt = pend_r & 4'he;
            if (grp_r == 5'd1) begin
              if (scap_pkg::fi_lookup(atr_byte[7:4]) == 12'd0) begin
                fl = 1'b1; fc = scap_pkg::StBadF;
              end else begin
                fi_nxt = scap_pkg::fi_lookup(atr_byte[7:4]);
                f_nxt = scap_pkg::f_lookup(atr_byte[7:4]);
                if (scap_pkg::d_lookup(atr_byte[3:0]) == 7'd0) begin
                  fl = 1'b1; fc = scap_pkg::StBadD;
                end else d_nxt = scap_pkg::d_lookup(atr_byte[3:0]);
              end
            end else if (grp_r == 5'd2) begin
              if (atr_byte[3:0] != 4'd1) begin
                fl = 1'b1; fc = scap_pkg::StBadTa2;
              end else t1_nxt = 1'b1;
            end else if (proto_r == 5'd1) ifsc_nxt = atr_byte;
          end else if (pend_r[1]) begin
            pend_nxt = pend_r & 4'hc;
            if (grp_r >= 5'd3 && proto_r == 5'd1) begin
              bwi_nxt = atr_byte[7:4]; cwi_nxt = atr_byte[3:0];
            end
          end else if (pend_r[2]) begin
            pend_nxt = pend_r & 4'h8;
            if (grp_r == 5'd1) n_nxt = atr_byte;
            else if (grp_r == 5'd2) wi_nxt = atr_byte;
            else if (proto_r == 5'd1) edc_nxt = atr_byte;
          end else begin
            pend_nxt = atr_byte[7:4];
            proto_nxt = {1'b0, atr_byte[3:0]};
            if (grp_r < 5'd31) grp_nxt = grp_r + 5'd1;
          end
          if (!fl && pend_nxt == 4'd0) ph_nxt = (hist_r != 4'd0) ? PhHist : PhTck;
        end
        PhHist: begin
          hist_nxt = hist_r - 4'd1;
          if (hist_nxt == 4'd0) ph_nxt = PhTck;
        end
        PhTck: ph_nxt = PhAfter;
        PhAfter: begin
          fl = 1'b1; fc = scap_pkg::StLength;
        end
        default: ;
      endcase
    end
    if (fl) begin
      ph_nxt = PhDrain;
      if (err_r == scap_pkg::StOk) err_nxt = fc;
    end
  end

  assign rem_try = {rem_r, dend_r[23]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      pos_r <= '0; ph_r <= PhTs; pend_r <= '0; hist_r <= '0; grp_r <= 5'd1;
      proto_r <= 5'd31; xor_r <= '0; err_r <= scap_pkg::StOk;
      fi_r <= 12'd372; f_r <= 5'd4; d_r <= 7'd1;
      ifsc_r <= 8'd32; bwi_r <= 4'd4; cwi_r <= 4'd13; edc_r <= '0; t1_r <= 1'b0;
      n_r <= '0; wi_r <= 8'd10;
    end else if (byte_en) begin
      if (pos_r < PosW'(MAX_ATR_BYTES)) begin
        pos_r <= pos_r + PosW'(1);
        if (pos_r != '0) xor_r <= xor_r ^ atr_byte;
      end
      ph_r <= ph_nxt; pend_r <= pend_nxt; hist_r <= hist_nxt; grp_r <= grp_nxt;
      proto_r <= proto_nxt; err_r <= err_nxt; fi_r <= fi_nxt; f_r <= f_nxt;
      d_r <= d_nxt; ifsc_r <= ifsc_nxt; edc_r <= edc_nxt; n_r <= n_nxt; wi_r <= wi_nxt;
      bwi_r <= bwi_nxt; cwi_r <= cwi_nxt; t1_r <= t1_nxt;
    end
  end

  // restoring divider, 24 quotient bits shifted into dend_r
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      if (cmd.div_sel_bwt) begin
        dend_r <= 24'(bwi_r) * 24'd714240;
        dvs_r <= {7'd0, f_r};
      end else begin
        dend_r <= {12'd0, fi_r};
        dvs_r <= 12'(d_r) * 12'(f_r);
      end
    end else if (cmd.div_step) begin
      if (!rem_try[12]) rem_r <= rem_try[11:0];
      else rem_r <= {rem_r[10:0], dend_r[23]};
      dend_r <= {dend_r[22:0], !rem_try[12]};
    end
    if (cmd.fin_etu) etu_r <= dend_r[6:0];
    if (cmd.fin_bwt) bwt_r <= dend_r[21:0] + 22'(etu_r) * 22'd11;
  end

  always_comb begin
    sts.status = err_r;
    if (sts.status == scap_pkg::StOk && ph_r != PhAfter) sts.status = scap_pkg::StLength;
    if (sts.status == scap_pkg::StOk && xor_r != 8'd0) sts.status = scap_pkg::StTck;
  end

  assign etu = etu_r;
  assign fi = fi_r;
  assign di = d_r;
  assign t1_en = t1_r;
  assign ifsc = ifsc_r;
  assign edc = edc_r;
  assign n_guard = n_r;
  assign wi = wi_r;
  assign bwt = bwt_r;
  assign cwt = 13'({1'b0, cwi_r, 1'b0} + 6'd11) * 13'(etu_r);
  assign bgt = 12'(etu_r) * 12'd22;
endmodule
`default_nettype wire

// ----- rtl/scap_ctrl.sv -----
// Controller: sequences byte intake, the two divisions and result delivery.
`default_nettype none
module scap_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_last,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic                     byte_en,
  output logic                     load_out,
  output scap_pkg::scap_cmd_t      cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DIV1, S_DIV2, S_FIN, S_OUT} state_t;
  localparam logic [4:0] LastStep = 5'd23;
  state_t st_r;
  logic [4:0] cnt_r;
  logic ov_r;
  // first DIV2 cycle latches etu and starts the second division
  logic start2_r;

  assign in_tready = (st_r == S_IDLE);
  assign byte_en = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign load_out = (st_r == S_OUT) && (!ov_r || out_tready);

  always_comb begin
    cmd = '0;
    case (st_r)
      S_IDLE: if (byte_en && in_last) cmd.div_start = 1'b1;
      S_DIV1: cmd.div_step = 1'b1;
      S_DIV2: begin
        cmd.div_sel_bwt = 1'b1;
        if (start2_r) begin
          cmd.div_start = 1'b1; cmd.fin_etu = 1'b1;
        end else cmd.div_step = 1'b1;
      end
      S_FIN: cmd.fin_bwt = 1'b1;
      S_OUT: cmd.clear = load_out;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0; start2_r <= 1'b0;
    end else begin
      if (load_out) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      start2_r <= (st_r == S_DIV1) && (cnt_r == LastStep);
      case (st_r)
        S_IDLE: if (byte_en && in_last) begin
          st_r <= S_DIV1; cnt_r <= '0;
        end
        S_DIV1: begin
          if (cnt_r == LastStep) begin
            st_r <= S_DIV2; cnt_r <= '0;
          end else cnt_r <= cnt_r + 5'd1;
        end
        S_DIV2: if (!start2_r) begin
          if (cnt_r == LastStep) begin
            st_r <= S_FIN; cnt_r <= '0;
          end else cnt_r <= cnt_r + 5'd1;
        end
        S_FIN: st_r <= S_OUT;
        S_OUT: if (load_out) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/smart_card_atr_parser.sv -----
// Top level of the smart card ATR parser.
// Takes one ATR byte per request (TS first, tlast on TCK), one byte per cycle
// while idle. On the last byte it runs two 24-step restoring divisions (etu,
// then the BWT term) and delivers one result through an output register;
// input is held off until that result is loaded into the register. The next ATR may
// start while that result waits; its own result is held until the register
// is free.
// Error results carry zeros in all fields but status.
`default_nettype none
module smart_card_atr_parser #(
  parameter int MAX_ATR_BYTES = scap_pkg::MaxAtrBytesDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // atr_byte
  input  wire logic         in_tlast,   // last_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[2:0] etu[9:3] clock_rate_factor[21:10] baud_divisor[28:22]
  // t1_enabled[29] ifsc[37:30] edc_mode[45:38] extra_guard[53:46]
  // wait_integer[61:54] block_wait_time[83:62] char_wait_time[96:84]
  // block_guard_time[108:97], zeros to 111
  output logic [111:0]      out_tdata
);
  scap_pkg::scap_cmd_t cmd;
  scap_pkg::scap_sts_t sts;
  logic byte_en, load_out;
  logic [6:0] etu, di;
  logic [11:0] fi, bgt;
  logic t1_en;
  logic [7:0] ifsc, edc, n_guard, wi;
  logic [21:0] bwt;
  logic [12:0] cwt;
  logic [111:0] out_r, out_nxt;
  logic ok;

  scap_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_last(in_tlast), .in_tready,
    .out_tvalid, .out_tready, .byte_en, .load_out, .cmd
  );

  scap_datapath #(.MAX_ATR_BYTES(MAX_ATR_BYTES)) u_dp (
    .clk, .rst_n, .byte_en, .atr_byte(in_tdata), .cmd, .sts,
    .etu, .fi, .di, .t1_en, .ifsc, .edc, .n_guard, .wi, .bwt, .cwt, .bgt
  );

  assign ok = (sts.status == scap_pkg::StOk);

  always_comb begin
    out_nxt = '0;
    out_nxt[2:0] = sts.status;
    if (ok) begin
      out_nxt[9:3] = etu;
      out_nxt[21:10] = fi;
      out_nxt[28:22] = di;
      out_nxt[29] = t1_en;
      out_nxt[37:30] = ifsc;
      out_nxt[45:38] = edc;
      out_nxt[53:46] = n_guard;
      out_nxt[61:54] = wi;
      if (t1_en) begin
        out_nxt[83:62] = bwt;
        out_nxt[96:84] = cwt;
        out_nxt[108:97] = bgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_r <= out_nxt;
  end

  assign out_tdata = out_r;
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the smart card ATR parser: generated ATRs, result check.
`timescale 1ns / 100ps
`default_nettype none

class atr_scoreboard;
  typedef struct packed {
    logic [11:0] bgt;
    logic [12:0] cwt;
    logic [21:0] bwt;
    logic [7:0] wi;
    logic [7:0] guard_n;
    logic [7:0] edc;
    logic [7:0] ifsc;
    logic t1_on;
    logic [6:0] di;
    logic [11:0] fi;
    logic [6:0] etu;
    logic [2:0] status;
  } atr_result_t;

  localparam int PhTs = 0, PhT0 = 1, PhIface = 2, PhHist = 3, PhTck = 4, PhAfter = 5,
    PhDrain = 6;
  localparam int ProtoNone = 31;
  localparam int MaxBytes = scap_pkg::MaxAtrBytesDefault;

  int pos, phase, pend, grp, proto, hist_left, err;
  logic [7:0] chk;
  int fi, fdiv, di, ifsc, bwi, cwi, edc, guard_n, wi;
  bit t1_on;
  atr_result_t pending_results[$];
  int errors;
  int results_seen;
  int status_hits[8];

  function new();
    errors = 0;
    results_seen = 0;
    clear_state();
  endfunction

  function void clear_state();
    pos = 0; phase = PhTs; pend = 0; grp = 1; proto = ProtoNone; hist_left = 0;
    chk = 0; err = 0; fi = 372; fdiv = 4; di = 1; ifsc = 32; bwi = 4; cwi = 13;
    edc = 0; t1_on = 0; guard_n = 0; wi = 10;
  endfunction

  function void flag(int code);
    if (err == 0) err = code;
    phase = PhDrain;
  endfunction

  function void iface(logic [7:0] v);
    int fi_t, f_t, d_t;
    if (pend[0]) begin
      pend = pend & 4'he;
      if (grp == 1) begin
        case (v[7:4])
          0: begin fi_t = 372; f_t = 4; end
          1: begin fi_t = 372; f_t = 5; end
          2: begin fi_t = 558; f_t = 6; end
          3: begin fi_t = 744; f_t = 8; end
          4: begin fi_t = 1116; f_t = 12; end
          5: begin fi_t = 1488; f_t = 16; end
          6: begin fi_t = 1860; f_t = 20; end
          9: begin fi_t = 512; f_t = 5; end
          10: begin fi_t = 768; f_t = 7; end
          11: begin fi_t = 1024; f_t = 10; end
          12: begin fi_t = 1536; f_t = 15; end
          13: begin fi_t = 2048; f_t = 20; end
          default: begin fi_t = 0; f_t = 0; end
        endcase
        if (fi_t == 0) begin flag(scap_pkg::StBadF); return; end
        fi = fi_t; fdiv = f_t;
        case (v[3:0])
          1: d_t = 1; 2: d_t = 2; 3: d_t = 4; 4: d_t = 8; 5: d_t = 16;
          6: d_t = 32; 7: d_t = 64; 8: d_t = 12; 9: d_t = 20;
          default: d_t = 0;
        endcase
        if (d_t == 0) begin flag(scap_pkg::StBadD); return; end
        di = d_t;
      end else if (grp == 2) begin
        if (v[3:0] != 1) begin flag(scap_pkg::StBadTa2); return; end
        t1_on = 1;
      end else if (proto == 1) ifsc = v;
    end else if (pend[1]) begin
      pend = pend & 4'hc;
      if (grp >= 3 && proto == 1) begin bwi = v[7:4]; cwi = v[3:0]; end
    end else if (pend[2]) begin
      pend = pend & 4'h8;
      if (grp == 1) guard_n = v;
      else if (grp == 2) wi = v;
      else if (proto == 1) edc = v;
    end else begin
      pend = v[7:4];
      proto = v[3:0];
      if (grp < 31) grp++;
    end
    if (pend == 0) phase = (hist_left != 0) ? PhHist : PhTck;
  endfunction

  function void note_request(logic [7:0] v, bit last);
    atr_result_t r;
    int st, e;
    if (pos >= MaxBytes) flag(scap_pkg::StLength);
    else begin
      if (pos >= 1) chk ^= v;
      pos++;
      case (phase)
        PhTs: if (v != scap_pkg::TsDirect) flag(scap_pkg::StBadTs); else phase = PhT0;
        PhT0: begin
          hist_left = v[3:0];
          pend = v[7:4];
          if (pend == 0) flag(scap_pkg::StNoIface); else phase = PhIface;
        end
        PhIface: iface(v);
        PhHist: begin
          hist_left--;
          if (hist_left == 0) phase = PhTck;
        end
        PhTck: phase = PhAfter;
        PhAfter: flag(scap_pkg::StLength);
        default: ;
      endcase
    end
    if (!last) return;
    r = '0;
    st = err;
    if (st == 0 && phase != PhAfter) st = scap_pkg::StLength;
    if (st == 0 && chk != 0) st = scap_pkg::StTck;
    r.status = 3'(st);
    if (st == 0) begin
      e = fi / (di * fdiv);
      r.etu = 7'(e); r.fi = 12'(fi); r.di = 7'(di); r.t1_on = t1_on;
      r.ifsc = 8'(ifsc); r.edc = 8'(edc); r.guard_n = 8'(guard_n); r.wi = 8'(wi);
      if (t1_on) begin
        r.bwt = 22'((2 * bwi * 960 * 372) / fdiv + 11 * e);
        r.cwt = 13'((2 * cwi + 11) * e);
        r.bgt = 12'(22 * e);
      end
    end
    status_hits[st]++;
    pending_results.push_back(r);
    clear_state();
  endfunction

  function void check_result(logic [111:0] d);
    atr_result_t got, want;
    got = d[108:0];
    results_seen++;
    if (pending_results.size() == 0) begin
      report("result with nothing pending", 0, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.etu != want.etu) report("etu", got.etu, want.etu);
    if (got.fi != want.fi) report("clock_rate_factor", got.fi, want.fi);
    if (got.di != want.di) report("baud_divisor", got.di, want.di);
    if (got.t1_on != want.t1_on) report("t1_enabled", got.t1_on, want.t1_on);
    if (got.ifsc != want.ifsc) report("ifsc", got.ifsc, want.ifsc);
    if (got.edc != want.edc) report("edc_mode", got.edc, want.edc);
    if (got.guard_n != want.guard_n) report("extra_guard", got.guard_n, want.guard_n);
    if (got.wi != want.wi) report("wait_integer", got.wi, want.wi);
    if (got.bwt != want.bwt) report("block_wait_time", got.bwt, want.bwt);
    if (got.cwt != want.cwt) report("char_wait_time", got.cwt, want.cwt);
    if (got.bgt != want.bgt) report("block_guard_time", got.bgt, want.bgt);
  endfunction

  function void report(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH result %0d %s: got %0d want %0d", results_seen, what, got, want);
  endfunction
endclass

module testbench;
  localparam int WatchdogLimit = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic [7:0] in_tdata = 0;
  logic in_tlast = 0;
  logic out_tready = 0;
  logic in_tready, out_tvalid;
  logic [111:0] out_tdata;

  atr_scoreboard atr_sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  int requests = 0;
  logic [7:0] atr_q[$];

  always #4 clk = ~clk;

  smart_card_atr_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      atr_sb.note_request(in_tdata, in_tlast);
      requests++;
    end
    if (rst_n && out_tvalid && out_tready) atr_sb.check_result(out_tdata);
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired after %0d requests", requests);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  // in_tready depends only on registered state, so it is stable at the falling edge
  task automatic send_byte(logic [7:0] v, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= v;
    in_tlast <= last;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_atr();
    for (int i = 0; i < atr_q.size(); i++) send_byte(atr_q[i], i == atr_q.size() - 1);
    atr_q.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (atr_sb.pending_results.size() != 0) @(negedge clk);
  endtask

  // Build an ATR, well-formed but for a bad TCK when fix_tck is clear; t1 adds TA2 and a T=1 group.
  task automatic build_atr(bit t1, int hist, bit fix_tck);
    logic [7:0] x;
    bit ta1, tc1, tc2;
    logic [3:0] fc, dc;
    int fcs[12] = '{0, 1, 2, 3, 4, 5, 6, 9, 10, 11, 12, 13};
    ta1 = 1'($urandom_range(1)); tc1 = 1'($urandom_range(1)); tc2 = 1'($urandom_range(1));
    fc = 4'(fcs[$urandom_range(11)]);
    dc = 4'($urandom_range(1, 9));
    atr_q.push_back(scap_pkg::TsDirect);
    atr_q.push_back({t1 | tc2, tc1, 1'b0, ta1, 4'(hist)});
    if (ta1) atr_q.push_back({fc, dc});
    if (tc1) atr_q.push_back(8'($urandom));
    if (t1 | tc2) begin
      atr_q.push_back({t1, tc2, 1'b0, t1, 4'($urandom)});
      if (t1) atr_q.push_back({4'($urandom), 4'd1});
      if (tc2) atr_q.push_back(8'($urandom));
      if (t1) begin
        atr_q.push_back({1'b1, 3'b111, 4'd1});
        atr_q.push_back(8'($urandom));
        atr_q.push_back(8'($urandom));
        atr_q.push_back(8'($urandom));
        atr_q.push_back($urandom_range(1) ? 8'h00 : 8'h01);
      end
    end
    for (int i = 0; i < hist; i++) atr_q.push_back(8'($urandom));
    x = 0;
    for (int i = 1; i < atr_q.size(); i++) x ^= atr_q[i];
    atr_q.push_back(fix_tck ? x : x ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic random_atr();
    int kind;
    kind = $urandom_range(99);
    build_atr(1'($urandom_range(1)), $urandom_range(3) == 0 ? $urandom_range(15) :
      $urandom_range(3), kind >= 8);
    if (kind < 80) ;
    else if (kind < 86) atr_q[$urandom_range(atr_q.size() - 1)] = 8'($urandom);
    else if (kind < 92) atr_q.delete(atr_q.size() - 1 - $urandom_range(atr_q.size() - 2));
    else if (kind < 96) atr_q.push_back(8'($urandom));
    else begin
      atr_q.delete();
      for (int i = $urandom_range(1, 70); i > 0; i--) atr_q.push_back(8'($urandom));
      if ($urandom_range(1)) atr_q[0] = scap_pkg::TsDirect;
    end
    send_atr();
  endtask

  initial begin
    atr_sb = new();
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    atr_q = '{8'h3B, 8'h10, 8'h11, 8'h11}; send_atr();
    atr_q = '{8'h3F, 8'h10, 8'h11, 8'h11}; send_atr();
    atr_q = '{8'h3B, 8'h00}; send_atr();
    atr_q = '{8'h3B, 8'h10, 8'h71, 8'h61}; send_atr();
    atr_q = '{8'h3B, 8'h10, 8'h10, 8'h00}; send_atr();
    atr_q = '{8'h3B, 8'h10, 8'hDA, 8'hCA}; send_atr();
    atr_q = '{8'h3B, 8'h10, 8'h17}; send_atr();
    atr_q = '{8'h3B, 8'h10, 8'h11, 8'h01, 8'h00}; send_atr();
    atr_q = '{8'h3B, 8'h10, 8'h11, 8'h00}; send_atr();
    atr_q = '{8'h3B, 8'h90, 8'h11, 8'h10, 8'h02, 8'h93}; send_atr();
    atr_q = '{8'h3B, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hF0}; send_atr();
    atr_q = '{8'h3B, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01, 8'h01};
    send_atr();
    atr_q = '{8'h3B};
    for (int i = 0; i < 66; i++) atr_q.push_back(8'hFF);
    send_atr();
    build_atr(1, 15, 1); send_atr();
    atr_q = '{8'h3B, 8'hB0, 8'hD9, 8'h00, 8'h81, 8'h21, 8'hFF, 8'h31, 8'hFE, 8'h00,
      8'hFF, 8'h84};
    for (int i = 1; i < 11; i++) atr_q[11] = (i == 1) ? atr_q[1] : atr_q[11] ^ atr_q[i];
    send_atr();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 12) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 79 : 12) : 0;
      for (int n = 0; n < 40; n++) random_atr();
      if (ph == 0) begin
        fork
          begin
            hold_off = 1;
            repeat (600) @(negedge clk);
            hold_off = 0;
          end
          for (int n = 0; n < 12; n++) random_atr();
        join
      end
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 30;
    while (requests < 1700) random_atr();
    wait_drained();
    repeat (200) @(negedge clk);
    $display("covered %0d bytes, %0d ATR results; status ok/TS/noif/F/D/TA2/len/TCK:",
      requests, atr_sb.results_seen);
    $display("  %0d %0d %0d %0d %0d %0d %0d %0d", atr_sb.status_hits[0],
      atr_sb.status_hits[1], atr_sb.status_hits[2], atr_sb.status_hits[3],
      atr_sb.status_hits[4], atr_sb.status_hits[5], atr_sb.status_hits[6],
      atr_sb.status_hits[7]);
    if (atr_sb.errors == 0 && atr_sb.pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
